[rtl/lspwm_pkg.sv]
`default_nettype none
package lspwm_pkg;

    localparam int PIXEL_COUNT_DEF = 16;

    localparam int CODE_W   = 16;
    localparam int CHAN_W   = 8;
    localparam int GRB_W    = 3 * CHAN_W;
    localparam int BIT_W    = 5;
    localparam int ANGLE_W  = 6;
    localparam int FACTOR_W = 17;
    localparam int IN_W     = 48;

    localparam logic [BIT_W-1:0]   TOP_BIT     = 5'd23;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 6'd45;
    localparam logic [7:0]         MODE_SINGLE = 8'h01;

    localparam logic [CODE_W-1:0] ONE_CODE_RST  = 16'd60;
    localparam logic [CODE_W-1:0] ZERO_CODE_RST = 16'd30;

    // configuration register indexes
    localparam logic REG_ONE_CODE  = 1'b0;
    localparam logic REG_ZERO_CODE = 1'b1;

    // item kind carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // sequencer phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BITS = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    // round(tan(angle deg) * 65536), unsigned q1.16
    localparam logic [FACTOR_W-1:0] TAN_Q16 [0:45] = '{
        17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
        17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
        17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
        17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
        17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
        17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
        17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
        17'd59009, 17'd61113, 17'd63288, 17'd65536
    };

    typedef struct packed {
        logic [GRB_W-1:0] grb;
        logic             single;
        logic [7:0]       target;
    } t_load;

    typedef struct packed {
        logic [CODE_W-1:0] duty;
        logic              valid;
        logic              last;
    } t_code;

endpackage
`default_nettype wire

[rtl/lspwm_scale.sv]
`default_nettype none
module lspwm_scale (
    input  wire logic [lspwm_pkg::CHAN_W-1:0] i_red,
    input  wire logic [lspwm_pkg::CHAN_W-1:0] i_green,
    input  wire logic [lspwm_pkg::CHAN_W-1:0] i_blue,
    input  wire logic [7:0]                   i_brightness,
    output logic      [lspwm_pkg::GRB_W-1:0]  o_grb
);
    localparam int PROD_W = lspwm_pkg::CHAN_W + lspwm_pkg::FACTOR_W;

    logic [lspwm_pkg::ANGLE_W-1:0]  angle;
    logic [lspwm_pkg::FACTOR_W-1:0] factor;
    logic [PROD_W-1:0]              prod_r;
    logic [PROD_W-1:0]              prod_g;
    logic [PROD_W-1:0]              prod_b;

    always_comb begin
        if (i_brightness > {2'b00, lspwm_pkg::MAX_ANGLE}) begin
            angle = lspwm_pkg::MAX_ANGLE;
        end else begin
            angle = i_brightness[lspwm_pkg::ANGLE_W-1:0];
        end
        factor = lspwm_pkg::TAN_Q16[angle];
        prod_r = PROD_W'(i_red)   * PROD_W'(factor);
        prod_g = PROD_W'(i_green) * PROD_W'(factor);
        prod_b = PROD_W'(i_blue)  * PROD_W'(factor);
    end

    // drop the 16 fraction bits, result never exceeds 255
    assign o_grb = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};

endmodule
`default_nettype wire

[rtl/lspwm_seq.sv]
`default_nettype none
module lspwm_seq #(
    parameter int PIXEL_COUNT = lspwm_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_action,
    input  wire lspwm_pkg::t_load              i_load,
    input  wire logic [lspwm_pkg::CODE_W-1:0]  i_one_code,
    input  wire logic [lspwm_pkg::CODE_W-1:0]  i_zero_code,
    output lspwm_pkg::t_code                   o_code
);
    localparam int PW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CW = (PW > 8) ? PW : 8;

    logic [lspwm_pkg::GRB_W-1:0] r_grb, n_grb;
    logic                        r_single, n_single;
    logic [7:0]                  r_target, n_target;
    logic [PW-1:0]               r_pix, n_pix;
    logic [lspwm_pkg::BIT_W-1:0] r_bit, n_bit;
    logic [1:0]                  r_phase, n_phase;

    logic [lspwm_pkg::GRB_W-1:0] word;
    logic                        cur_bit;

    always_comb begin
        word = r_grb;
        if (r_single && (CW'(r_pix) != CW'(r_target))) begin
            word = '0;
        end
        cur_bit = word[r_bit];

        n_grb    = r_grb;
        n_single = r_single;
        n_target = r_target;
        n_pix    = r_pix;
        n_bit    = r_bit;
        n_phase  = r_phase;
        o_code   = '0;

        if (i_action == lspwm_pkg::ACT_LOAD) begin
            // a load abandons any frame in progress
            n_grb    = i_load.grb;
            n_single = i_load.single;
            n_target = i_load.target;
            n_pix    = '0;
            n_bit    = lspwm_pkg::TOP_BIT;
            n_phase  = lspwm_pkg::PH_BITS;
        end else begin
            case (r_phase)
                lspwm_pkg::PH_BITS: begin
                    o_code.duty  = cur_bit ? i_one_code : i_zero_code;
                    o_code.valid = 1'b1;
                    if (r_bit == '0) begin
                        n_bit = lspwm_pkg::TOP_BIT;
                        if (r_pix == PW'(PIXEL_COUNT - 1)) begin
                            n_pix   = '0;
                            n_phase = lspwm_pkg::PH_END;
                        end else begin
                            n_pix = r_pix + 1'b1;
                        end
                    end else begin
                        n_bit = r_bit - 1'b1;
                    end
                end
                lspwm_pkg::PH_END: begin
                    o_code.valid = 1'b1;
                    o_code.last  = 1'b1;
                    n_pix        = '0;
                    n_bit        = lspwm_pkg::TOP_BIT;
                    n_phase      = lspwm_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = lspwm_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grb    <= '0;
            r_single <= 1'b0;
            r_target <= '0;
            r_pix    <= '0;
            r_bit    <= lspwm_pkg::TOP_BIT;
            r_phase  <= lspwm_pkg::PH_IDLE;
        end else if (i_step) begin
            r_grb    <= n_grb;
            r_single <= n_single;
            r_target <= n_target;
            r_pix    <= n_pix;
            r_bit    <= n_bit;
            r_phase  <= n_phase;
        end
    end

endmodule
`default_nettype wire

[rtl/led_strip_pwm_code_serializer.sv]
`default_nettype none
// a result passes through the input register, then the result register, onto m_axis
// one item per cycle unless m_axis stalls; a load gives no result, a tick gives one
// the input register and the result register both advance when the result is taken
// or empty, so ready follows m_axis_tready within the cycle
// reset is synchronous and active low: codes return to 60 and 30, sequencer idle
module led_strip_pwm_code_serializer #(
    parameter int PIXEL_COUNT = lspwm_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // red, green, blue, brightness, pattern_mode, lit_position (8 bits each)
    input  wire logic [47:0] s_axis_tdata,
    // action
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // duty
    output logic [15:0]      m_axis_tdata,
    // code_valid
    output logic             m_axis_tuser,
    // frame_last
    output logic             m_axis_tlast
);
    logic [lspwm_pkg::CODE_W-1:0] r_one_code;
    logic [lspwm_pkg::CODE_W-1:0] r_zero_code;

    logic                         r_in_valid;
    logic                         r_in_action;
    logic [lspwm_pkg::IN_W-1:0]   r_in_data;

    logic                         r_out_valid;
    lspwm_pkg::t_code             r_out;

    logic                         advance;
    logic                         step;
    logic [lspwm_pkg::GRB_W-1:0]  scaled_grb;
    lspwm_pkg::t_load             load;
    lspwm_pkg::t_code             code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_code  <= lspwm_pkg::ONE_CODE_RST;
            r_zero_code <= lspwm_pkg::ZERO_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lspwm_pkg::REG_ONE_CODE:  r_one_code  <= i_cfg_wdata;
                lspwm_pkg::REG_ZERO_CODE: r_zero_code <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = advance && r_in_valid;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_data   <= s_axis_tdata;
        end
    end

    lspwm_scale u_scale (
        .i_red        (r_in_data[7:0]),
        .i_green      (r_in_data[15:8]),
        .i_blue       (r_in_data[23:16]),
        .i_brightness (r_in_data[31:24]),
        .o_grb        (scaled_grb)
    );

    always_comb begin
        load.grb    = scaled_grb;
        load.single = (r_in_data[39:32] == lspwm_pkg::MODE_SINGLE);
        load.target = r_in_data[47:40];
    end

    lspwm_seq #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_action    (r_in_action),
        .i_load      (load),
        .i_one_code  (r_one_code),
        .i_zero_code (r_zero_code),
        .o_code      (code)
    );

    // only ticks produce a transfer on the output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && (r_in_action == lspwm_pkg::ACT_TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.duty;
    assign m_axis_tuser  = r_out.valid;
    assign m_axis_tlast  = r_out.last;

    a_last_is_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("frame end code without code_valid");

    a_idle_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("idle tick with nonzero duty or frame end");

    a_in_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_data))
        else $error("pending input item dropped while output stalled");

    a_load_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (r_in_action == lspwm_pkg::ACT_LOAD) |=> !r_out_valid)
        else $error("load item produced an output transfer");

endmodule
`default_nettype wire

[dv/lspwm_code_checker.sv]
`timescale 1ns / 1ps
module lspwm_code_checker #(
    parameter int PIXELS = lspwm_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [47:0] i_in_data,
    input  wire logic        i_in_user,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_out_data,
    input  wire logic        i_out_user,
    input  wire logic        i_out_last,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked,
    output int               o_frame_ends
);

    // tan(deg) in unsigned q1.16, degrees 0..45
    localparam logic [16:0] TAN_TABLE [0:45] = '{
        17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
        17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
        17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
        17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
        17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
        17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
        17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
        17'd59009, 17'd61113, 17'd63288, 17'd65536
    };

    logic [15:0] code_one  = lspwm_pkg::ONE_CODE_RST;
    logic [15:0] code_zero = lspwm_pkg::ZERO_CODE_RST;
    logic [23:0] strip_grb = '0;
    logic        one_pixel_only = 1'b0;
    logic [7:0]  lit_index = '0;
    int          pix_cnt = 0;
    logic [4:0]  bit_pos = lspwm_pkg::TOP_BIT;
    logic [1:0]  seq_phase = lspwm_pkg::PH_IDLE;

    lspwm_pkg::t_code codes_due[$];
    int    fault_count = 0;
    int    checked_cnt = 0;
    int    frame_end_cnt = 0;

    assign o_errors     = fault_count;
    assign o_checked    = checked_cnt;
    assign o_frame_ends = frame_end_cnt;

    function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [16:0] factor);
        logic [24:0] prod;
        prod = c * factor;
        return prod[23:16];
    endfunction

    task automatic latch_frame(input logic [47:0] f);
        logic [5:0]  angle;
        logic [16:0] factor;
        angle  = (f[31:24] > lspwm_pkg::MAX_ANGLE) ? lspwm_pkg::MAX_ANGLE : f[29:24];
        factor = TAN_TABLE[angle];
        // stored as green, red, blue from the top down
        strip_grb      = {dim_channel(f[15:8], factor), dim_channel(f[7:0], factor),
                          dim_channel(f[23:16], factor)};
        one_pixel_only = (f[39:32] == lspwm_pkg::MODE_SINGLE);
        lit_index      = f[47:40];
        pix_cnt        = 0;
        bit_pos        = lspwm_pkg::TOP_BIT;
        seq_phase      = lspwm_pkg::PH_BITS;
    endtask

    task automatic next_pwm_code(output lspwm_pkg::t_code c);
        logic [23:0] word;
        logic        level;
        c = '0;
        case (seq_phase)
            lspwm_pkg::PH_BITS: begin
                word = (one_pixel_only && pix_cnt != int'(lit_index)) ? '0 : strip_grb;
                level = word[bit_pos];
                c.duty  = level ? code_one : code_zero;
                c.valid = 1'b1;
                if (bit_pos == 0) begin
                    bit_pos = lspwm_pkg::TOP_BIT;
                    pix_cnt++;
                    if (pix_cnt >= PIXELS) seq_phase = lspwm_pkg::PH_END;
                end else begin
                    bit_pos--;
                end
            end
            lspwm_pkg::PH_END: begin
                c.valid   = 1'b1;
                c.last    = 1'b1;
                seq_phase = lspwm_pkg::PH_IDLE;
                pix_cnt   = 0;
                bit_pos   = lspwm_pkg::TOP_BIT;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fault_count++;
        $display("code check: result %0d %s got 0x%0h want 0x%0h",
                 checked_cnt, what, got, want);
    endtask

    always @(posedge i_clk) begin
        lspwm_pkg::t_code want;
        if (!i_rst_n) begin
            code_one       = lspwm_pkg::ONE_CODE_RST;
            code_zero      = lspwm_pkg::ZERO_CODE_RST;
            strip_grb      = '0;
            one_pixel_only = 1'b0;
            lit_index      = '0;
            pix_cnt        = 0;
            bit_pos        = lspwm_pkg::TOP_BIT;
            seq_phase      = lspwm_pkg::PH_IDLE;
            codes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lspwm_pkg::REG_ONE_CODE:  code_one  = i_cfg_wdata;
                    lspwm_pkg::REG_ZERO_CODE: code_zero = i_cfg_wdata;
                    default: ;
                endcase
            end
            // the result of this edge's input transfer cannot appear before the next edge
            if (i_out_valid && i_out_ready) begin
                if (codes_due.size() == 0) begin
                    report_mismatch("with nothing expected, duty", i_out_data, 0);
                end else begin
                    want = codes_due.pop_front();
                    if (i_out_data != want.duty)  report_mismatch("duty", i_out_data, want.duty);
                    if (i_out_user != want.valid) report_mismatch("code_valid", i_out_user, want.valid);
                    if (i_out_last != want.last)  report_mismatch("frame_last", i_out_last, want.last);
                    if (want.last) frame_end_cnt++;
                end
                checked_cnt++;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user == lspwm_pkg::ACT_LOAD) begin
                    latch_frame(i_in_data);
                end else begin
                    next_pwm_code(want);
                    codes_due.push_back(want);
                end
            end
        end
        o_pending = codes_due.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int PIXELS      = lspwm_pkg::PIXEL_COUNT_DEF;
    localparam int FRAME_TICKS = PIXELS * 24 + 1;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = lspwm_pkg::REG_ONE_CODE;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = lspwm_pkg::ACT_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int   err_cnt;
    int   codes_pending;
    int   codes_checked;
    int   frame_ends;
    int   cycle_cnt     = 0;
    int   items_sent    = 0;
    int   loads_sent    = 0;
    logic long_hold_req = 1'b0;
    bit   feed_gaps     = 1'b1;

    led_strip_pwm_code_serializer #(.PIXEL_COUNT(PIXELS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lspwm_code_checker #(.PIXELS(PIXELS)) u_code_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_errors     (err_cnt),
        .o_pending    (codes_pending),
        .o_checked    (codes_checked),
        .o_frame_ends (frame_ends)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // offers one item and returns right after the edge of its transfer
    task automatic send_item(input logic act, input logic [47:0] fields);
        int gap;
        if (feed_gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {16'($urandom), $urandom};
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fields;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (act == lspwm_pkg::ACT_LOAD) loads_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(lspwm_pkg::ACT_TICK, {16'($urandom), $urandom});
    endtask

    // block is idle once every expected code is back and the pipe has emptied
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (codes_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [15:0] one_val, input logic [15:0] zero_val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= lspwm_pkg::REG_ONE_CODE;
        i_cfg_wdata <= one_val;
        @(posedge i_clk);
        i_cfg_addr  <= lspwm_pkg::REG_ZERO_CODE;
        i_cfg_wdata <= zero_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one load and a run of ticks, either a whole frame or a piece of one
    task automatic frame_burst(input bit whole);
        logic [7:0] mode;
        logic [7:0] pos;
        logic [7:0] bright;
        int         ticks;
        case ($urandom_range(0, 3))
            0, 1:    mode = lspwm_pkg::MODE_SINGLE;
            2:       mode = 8'($urandom);
            default: mode = $urandom_range(0, 1) ? 8'h00 : 8'hff;
        endcase
        pos    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, PIXELS + 1));
        bright = $urandom_range(0, 1) ? 8'($urandom_range(0, 50)) : 8'($urandom);
        feed_gaps = ($urandom_range(0, 3) != 0);
        send_item(lspwm_pkg::ACT_LOAD, {pos, mode, bright, 24'($urandom)});
        if (whole)
            ticks = FRAME_TICKS + $urandom_range(0, 3);
        else if ($urandom_range(0, 3) == 0)
            ticks = $urandom_range(60, 300);
        else
            ticks = $urandom_range(0, 40);
        send_ticks(ticks);
    endtask

    initial begin : sink
        int  run;
        int  gap;
        bit  held;
        held = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
            if ($urandom_range(0, 4) < 3) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int ph;
        int phase_start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fields from the top: position, mode, brightness, blue, green, red
        send_ticks(2);                                                  // idle ticks
        send_item(lspwm_pkg::ACT_LOAD, {8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff});
        send_ticks(3);
        // reload mid-frame, single pixel at 0, full angle
        send_item(lspwm_pkg::ACT_LOAD, {8'h00, 8'h01, 8'd45, 8'h7f, 8'h80, 8'h01});
        send_ticks(4);
        send_item(lspwm_pkg::ACT_LOAD, {8'h0f, 8'hff, 8'd0, 8'hff, 8'h55, 8'haa});
        send_ticks(2);
        // angle just over the clamp, lit pixel past the strip end
        send_item(lspwm_pkg::ACT_LOAD, {8'h10, 8'h01, 8'd46, 8'hff, 8'h00, 8'hff});
        send_ticks(3);
        send_item(lspwm_pkg::ACT_LOAD, {8'h01, 8'h01, 8'd1, 8'h00, 8'hff, 8'hff});
        send_ticks(2);

        for (ph = 0; ph < 3; ph++) begin
            settle();
            case (ph)
                0:       write_codes(16'hffff, 16'h0000);
                1:       write_codes(16'h0000, 16'hffff);
                default: write_codes(16'($urandom), 16'($urandom));
            endcase
            phase_start = items_sent;
            if (ph == 0) begin
                long_hold_req <= 1'b1;
                frame_burst(1'b1);
            end
            while (items_sent - phase_start < PHASE_ITEMS)
                frame_burst($urandom_range(0, 4) == 0);
        end

        settle();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        $display("run: %0d loads and %0d ticks sent over four code settings",
                 loads_sent, items_sent - loads_sent);
        $display("run: %0d codes compared, %0d frames ran out to the end code",
                 codes_checked, frame_ends);
        if (err_cnt == 0 && codes_pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
